// ===== src/gpk_pkg.sv =====
// Package for the glyph row packer: entry, cell control and result types,
// kind, status and state codes. No dependencies.
package gpk_pkg;

  localparam int CODE_W = 8;
  localparam int DIM_W  = 8;
  localparam int POS_W  = 16;
  localparam int ROWC_W = 5;
  localparam int PAD_W  = 4;

  // Configuration register indexes (paddr[2])
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_PADDING   = 1'b1;

  localparam logic [ROWC_W-1:0] ROW_COUNT_RST = 5'd12;
  localparam logic [PAD_W-1:0]  PADDING_RST   = 4'd1;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_READ  = 2'd2
  } gpk_kind_e;

  typedef enum logic [1:0] {
    STS_PLACED = 2'd0,
    STS_EMPTY  = 2'd1,
    STS_FULL   = 2'd2
  } gpk_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_FULL,
    S_ALIGN,
    S_SWEEP,
    S_WIDTH,
    S_SEEK
  } gpk_state_e;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
  } gpk_entry_t;

  typedef enum logic [1:0] {
    SOP_HOLD,
    SOP_INSERT,
    SOP_ROTATE
  } gpk_store_op_e;

  typedef struct packed {
    gpk_store_op_e op;
    gpk_entry_t    ins;
  } gpk_store_ctl_t;

  typedef struct packed {
    logic [POS_W-1:0] top;
    logic [POS_W-1:0] xsum;
  } gpk_row_t;

  typedef enum logic {
    ROP_HOLD,
    ROP_ROTATE
  } gpk_row_op_e;

  typedef struct packed {
    gpk_row_op_e op;
    gpk_row_t    wrap;
  } gpk_row_ctl_t;

  typedef struct packed {
    gpk_status_e       status;
    logic [CODE_W-1:0] code;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [POS_W-1:0]  atlas_w;
    logic [POS_W-1:0]  atlas_h;
    logic              last;
  } gpk_result_t;

endpackage

// ===== src/gpk_glyph_cell.sv =====
// One cell of the height-sorted glyph chain: holds one entry, takes part in
// stable insertion and in rotation toward cell 0. Depends on gpk_pkg.
module gpk_glyph_cell
  import gpk_pkg::*;
(
  input  logic           clk_i,
  input  gpk_store_ctl_t ctl_i,
  input  logic           live_i,       // this cell holds a loaded entry
  input  logic           prev_keep_i,  // neighbor below keeps its entry
  input  gpk_entry_t     prev_i,       // entry of neighbor below
  input  gpk_entry_t     next_i,       // entry of neighbor above
  output logic           keep_o,
  output gpk_entry_t     entry_o
);

  gpk_entry_t entry_q;
  gpk_entry_t entry_d;

  // Entries at least as tall as the new one stay put (ties keep order)
  assign keep_o = live_i && (entry_q.h >= ctl_i.ins.h);

  always_comb begin
    entry_d = entry_q;
    case (ctl_i.op)
      SOP_INSERT: begin
        if (!keep_o) begin
          entry_d = prev_keep_i ? ctl_i.ins : prev_i;
        end
      end
      SOP_ROTATE: entry_d = next_i;
      default:    entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== src/gpk_row_cell.sv =====
// One cell of the row ring: top y and running end x of one atlas row.
// Cell 0 is the current row; the tail cell takes the updated head value.
// Depends on gpk_pkg.
module gpk_row_cell
  import gpk_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  gpk_row_ctl_t ctl_i,
  input  logic         tail_i,  // last cell of the active ring
  input  gpk_row_t     next_i,
  output gpk_row_t     cell_o
);

  gpk_row_t cell_q;
  gpk_row_t cell_d;

  always_comb begin
    cell_d = cell_q;
    case (ctl_i.op)
      ROP_ROTATE: cell_d = tail_i ? ctl_i.wrap : next_i;
      default:    cell_d = cell_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== src/glyph_row_packer.sv =====
// Glyph row packer top level: stream ports, APB registers, sequencer; uses gpk_pkg and cells.
// Clear and kind 3 are handled in the idle state. Load: the glyph chain rotates entry 0
// back to cell 0, then inserts. Dropped load: waits out output stalls.
// Read: seeks the entry, then waits out output stalls; the first read after a change
// adds the layout build (align, sweep and width states).
// Reset (rst_ni, async, low) clears control and row cells; glyph cells are not cleared.
module glyph_row_packer
  import gpk_pkg::*;
#(
  parameter int MAX_GLYPHS = 128,
  parameter int MAX_ROWS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // code[7:0], glyph_width[15:8], glyph_height[23:16]
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], out_code[9:2], pos_x[25:10], pos_y[41:26], out_width[49:42],
  // out_height[57:50], atlas_width[73:58], atlas_height[89:74], zero[95:90]
  output logic [95:0] m_axis_tdata,
  output logic        m_axis_tlast,   // last
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW   = $clog2(MAX_GLYPHS + 1);
  localparam int HW   = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
  localparam int RW   = $clog2(MAX_ROWS + 1);
  localparam int RRW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int IDXW = $clog2(MAX_GLYPHS + MAX_ROWS + 1);

  gpk_state_e        state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [HW-1:0]     head_q, head_d, head_inc;
  gpk_entry_t        ins_q, ins_d;
  logic              layout_ready_q, layout_ready_d;
  logic [RW-1:0]     read_row_q, read_row_d;
  logic [IDXW-1:0]   idx_q, idx_d;
  logic [POS_W-1:0]  running_x_q, running_x_d;
  logic [POS_W-1:0]  width_total_q, width_total_d;
  logic [POS_W-1:0]  height_total_q, height_total_d;
  logic [RRW-1:0]    ring_row_q, ring_row_d, ring_row_inc;
  logic [RW-1:0]     wcnt_q, wcnt_d;
  logic [ROWC_W-1:0] row_count_q;
  logic [PAD_W-1:0]  padding_q;
  logic              out_valid_q;
  gpk_result_t       out_q, res_d;
  logic              emit;

  logic              s_acc, cfg_we, slot_free;
  gpk_kind_e         kind;
  logic [RW-1:0]     rows;
  gpk_store_ctl_t    store_ctl;
  gpk_row_ctl_t      row_ctl;
  gpk_entry_t        head_e;
  gpk_row_t          head_r;
  logic [POS_W-1:0]  add_x;
  logic              sw_first, sw_has, seek_last;
  logic [IDXW-1:0]   idx_inc, count_x, rows_x, filled_x;

  gpk_entry_t        store_q  [MAX_GLYPHS];
  gpk_entry_t        s_prev   [MAX_GLYPHS];
  logic              s_keep   [MAX_GLYPHS];
  logic              s_pkeep  [MAX_GLYPHS];
  gpk_row_t          ring_q   [MAX_ROWS];

  assign s_acc     = s_axis_tvalid && s_axis_tready;
  assign kind      = gpk_kind_e'(s_axis_tuser);
  assign cfg_we    = psel && penable && pwrite && pready;
  assign slot_free = !out_valid_q || m_axis_tready;

  // Effective row count: 0 acts as 1, clamp at MAX_ROWS
  always_comb begin
    if (row_count_q == '0) begin
      rows = RW'(1);
    end else if (int'(row_count_q) > MAX_ROWS) begin
      rows = RW'(MAX_ROWS);
    end else begin
      rows = RW'(row_count_q);
    end
  end

  // Glyph chain
  for (genvar i = 0; i < MAX_GLYPHS; i++) begin : g_store
    if (i == 0) begin : g_first
      assign s_pkeep[i] = 1'b1;
      assign s_prev[i]  = store_ctl.ins;
    end else begin : g_rest
      assign s_pkeep[i] = s_keep[i-1];
      assign s_prev[i]  = store_q[i-1];
    end
    gpk_glyph_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (store_ctl),
      .live_i      (CW'(i) < count_q),
      .prev_keep_i (s_pkeep[i]),
      .prev_i      (s_prev[i]),
      .next_i      (store_q[(i + 1) % MAX_GLYPHS]),
      .keep_o      (s_keep[i]),
      .entry_o     (store_q[i])
    );
  end

  // Row ring
  for (genvar j = 0; j < MAX_ROWS; j++) begin : g_ring
    gpk_row_cell u_row (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (row_ctl),
      .tail_i (RW'(j) == rows - 1'b1),
      .next_i (ring_q[(j + 1) % MAX_ROWS]),
      .cell_o (ring_q[j])
    );
  end

  assign head_e   = store_q[0];
  assign head_r   = ring_q[0];
  assign add_x    = POS_W'(head_e.w) + POS_W'(padding_q);
  assign head_inc = (head_q == HW'(MAX_GLYPHS - 1)) ? '0 : head_q + 1'b1;
  assign ring_row_inc = (RW'(ring_row_q) + 1'b1 == rows) ? '0 : ring_row_q + 1'b1;
  assign idx_inc  = idx_q + 1'b1;
  assign count_x  = IDXW'(count_q);
  assign rows_x   = IDXW'(rows);
  assign filled_x = (count_x < rows_x) ? count_x : rows_x;
  assign sw_first = idx_q < rows_x;
  assign sw_has   = idx_q < count_x;
  assign seek_last = (idx_q + rows_x >= count_x) && (IDXW'(read_row_q) + 1'b1 >= filled_x);

  // Sequencer
  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    head_d         = head_q;
    ins_d          = ins_q;
    layout_ready_d = layout_ready_q;
    read_row_d     = read_row_q;
    idx_d          = idx_q;
    running_x_d    = running_x_q;
    width_total_d  = width_total_q;
    height_total_d = height_total_q;
    ring_row_d     = ring_row_q;
    wcnt_d         = wcnt_q;
    store_ctl.op   = SOP_HOLD;
    store_ctl.ins  = ins_q;
    row_ctl.op     = ROP_HOLD;
    row_ctl.wrap   = head_r;
    emit           = 1'b0;
    res_d          = '0;
    s_axis_tready  = 1'b0;

    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_acc) begin
          case (kind)
            KIND_CLEAR: begin
              count_d        = '0;
              layout_ready_d = 1'b0;
              read_row_d     = '0;
              idx_d          = '0;
              running_x_d    = '0;
            end
            KIND_LOAD: begin
              if (count_q == CW'(MAX_GLYPHS)) begin
                state_d = S_FULL;
              end else begin
                ins_d.code = s_axis_tdata[7:0];
                ins_d.w    = s_axis_tdata[15:8];
                ins_d.h    = s_axis_tdata[23:16];
                state_d    = S_LOAD;
              end
            end
            KIND_READ: state_d = layout_ready_q ? S_SEEK : S_ALIGN;
            default: ;
          endcase
        end
      end

      // rotate entry 0 back to cell 0, then insert
      S_LOAD: begin
        if (head_q == '0) begin
          store_ctl.op   = SOP_INSERT;
          count_d        = count_q + 1'b1;
          layout_ready_d = 1'b0;
          read_row_d     = '0;
          idx_d          = '0;
          running_x_d    = '0;
          state_d        = S_IDLE;
        end else begin
          store_ctl.op = SOP_ROTATE;
          head_d       = head_inc;
        end
      end

      S_FULL: begin
        if (slot_free) begin
          emit         = 1'b1;
          res_d.status = STS_FULL;
          state_d      = S_IDLE;
        end
      end

      S_ALIGN: begin
        if (head_q == '0) begin
          idx_d          = '0;
          ring_row_d     = '0;
          height_total_d = '0;
          width_total_d  = '0;
          state_d        = S_SWEEP;
        end else begin
          store_ctl.op = SOP_ROTATE;
          head_d       = head_inc;
        end
      end

      // one entry per cycle through cell 0; the ring rotates with it
      S_SWEEP: begin
        store_ctl.op = SOP_ROTATE;
        head_d       = head_inc;
        row_ctl.op   = ROP_ROTATE;
        ring_row_d   = ring_row_inc;
        if (sw_first) begin
          row_ctl.wrap.top  = height_total_q;
          row_ctl.wrap.xsum = sw_has ? add_x : '0;
          height_total_d    = height_total_q + (sw_has ? POS_W'(head_e.h) : '0)
                              + POS_W'(padding_q);
        end else if (sw_has) begin
          row_ctl.wrap.xsum = head_r.xsum + add_x;
        end
        idx_d = idx_inc;
        if (idx_inc >= count_x && idx_inc >= rows_x) begin
          wcnt_d  = '0;
          state_d = S_WIDTH;
        end
      end

      // max of row ends over one lap, then stop with row 0 in cell 0
      S_WIDTH: begin
        row_ctl.op = ROP_ROTATE;
        ring_row_d = ring_row_inc;
        if (wcnt_q < rows) begin
          wcnt_d = wcnt_q + 1'b1;
          if (head_r.xsum > width_total_q) begin
            width_total_d = head_r.xsum;
          end
        end
        if (wcnt_q >= rows - 1'b1 && ring_row_inc == '0) begin
          layout_ready_d = 1'b1;
          read_row_d     = '0;
          idx_d          = '0;
          running_x_d    = '0;
          state_d        = S_SEEK;
        end
      end

      S_SEEK: begin
        if (read_row_q >= rows) begin
          if (slot_free) begin
            emit          = 1'b1;
            res_d.status  = STS_EMPTY;
            res_d.atlas_w = width_total_q;
            res_d.atlas_h = height_total_q;
            state_d       = S_IDLE;
          end
        end else if (!sw_has) begin
          // row exhausted: next row comes to cell 0
          row_ctl.op  = ROP_ROTATE;
          read_row_d  = read_row_q + 1'b1;
          idx_d       = IDXW'(read_row_q) + 1'b1;
          running_x_d = '0;
        end else if (IDXW'(head_q) != idx_q) begin
          store_ctl.op = SOP_ROTATE;
          head_d       = head_inc;
        end else if (slot_free) begin
          emit          = 1'b1;
          res_d.status  = STS_PLACED;
          res_d.code    = head_e.code;
          res_d.pos_x   = running_x_q;
          res_d.pos_y   = head_r.top;
          res_d.w       = head_e.w;
          res_d.h       = head_e.h;
          res_d.atlas_w = width_total_q;
          res_d.atlas_h = height_total_q;
          res_d.last    = seek_last;
          running_x_d   = running_x_q + add_x;
          idx_d         = idx_q + rows_x;
          state_d       = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // a register write discards the layout
    if (cfg_we) begin
      layout_ready_d = 1'b0;
      read_row_d     = '0;
      idx_d          = '0;
      running_x_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      count_q        <= '0;
      head_q         <= '0;
      layout_ready_q <= 1'b0;
      read_row_q     <= '0;
      idx_q          <= '0;
      running_x_q    <= '0;
      width_total_q  <= '0;
      height_total_q <= '0;
      ring_row_q     <= '0;
      wcnt_q         <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      count_q        <= count_d;
      head_q         <= head_d;
      layout_ready_q <= layout_ready_d;
      read_row_q     <= read_row_d;
      idx_q          <= idx_d;
      running_x_q    <= running_x_d;
      width_total_q  <= width_total_d;
      height_total_q <= height_total_d;
      ring_row_q     <= ring_row_d;
      wcnt_q         <= wcnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ins_q <= ins_d;
    if (emit) begin
      out_q <= res_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROW_COUNT_RST;
      padding_q   <= PADDING_RST;
    end else if (cfg_we) begin
      if (paddr[2] == REG_ROW_COUNT) begin
        row_count_q <= pwdata[ROWC_W-1:0];
      end else begin
        padding_q <= pwdata[PAD_W-1:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PADDING) ? {{(32 - PAD_W){1'b0}}, padding_q}
                                            : {{(32 - ROWC_W){1'b0}}, row_count_q};

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {6'b0, out_q.atlas_h, out_q.atlas_w, out_q.h, out_q.w,
                          out_q.pos_y, out_q.pos_x, out_q.code, out_q.status};

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_GLYPHS))
    else $error("glyph count above capacity");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && kind == KIND_LOAD && count_q == CW'(MAX_GLYPHS)) |=> state_q == S_FULL)
    else $error("load into full store not dropped");

  a_seek_layout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEEK |-> layout_ready_q)
    else $error("placement lookup without a layout");

  a_width_lap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WIDTH |-> wcnt_q <= rows)
    else $error("row lap counter overran");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Testbench for glyph_row_packer: directed and random clear/load/read words,
// every result word checked against an in-bench shelf packing predictor.
// Depends on gpk_pkg and the glyph_row_packer RTL.
module tb;
  import gpk_pkg::*;

  localparam int GLYPH_CAP = 128;
  localparam int ROW_CAP = 16;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  // worst-case busy time of a load or a layout build, with margin
  localparam int SETTLE_CYCLES = 400;
  localparam int WORK_TARGET = 950;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] code;
    logic [7:0] w;
    logic [7:0] h;
  } glyph_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // code[7:0], glyph_width[15:8], glyph_height[23:16]
  logic [1:0]  s_axis_tuser = '0;   // kind[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // status[1:0], out_code[9:2], pos_x[25:10], pos_y[41:26], out_width[49:42],
  // out_height[57:50], atlas_width[73:58], atlas_height[89:74], zero[95:90]
  logic [95:0] m_axis_tdata;
  logic        m_axis_tlast;        // last
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  glyph_row_packer #(
    .MAX_GLYPHS(GLYPH_CAP),
    .MAX_ROWS  (ROW_CAP)
  ) i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  // Bench bookkeeping
  glyph_word_t  word_backlog[$];
  gpk_result_t  placements_due[$];
  glyph_word_t  on_bus;
  int unsigned  sent_total = 0;
  int unsigned  taken_total = 0;
  int unsigned  work_items = 0;
  int unsigned  mismatches = 0;
  bit           steady = 1'b0;

  // Predictor state: sorted shelf, layout and read cursor
  gpk_entry_t        shelf[GLYPH_CAP];
  int unsigned       n_glyphs = 0;
  logic [15:0]       row_y[ROW_CAP];
  bit                laid_out = 1'b0;
  int unsigned       cur_row = 0;
  int unsigned       cur_slot = 0;
  logic [15:0]       cur_x = '0;
  logic [15:0]       atlas_w_m = '0;
  logic [15:0]       atlas_h_m = '0;
  logic [ROWC_W-1:0] rows_cfg = ROW_COUNT_RST;
  logic [PAD_W-1:0]  pad_cfg = PADDING_RST;

  function automatic int unsigned live_rows();
    int unsigned rows;
    rows = rows_cfg;
    if (rows == 0) rows = 1;
    if (rows > ROW_CAP) rows = ROW_CAP;
    return rows;
  endfunction

  function automatic void rewind();
    laid_out = 1'b0;
    cur_row = 0;
    cur_slot = 0;
    cur_x = '0;
  endfunction

  // Row tops and atlas size; row height is the height of its first glyph
  function automatic void relayout();
    int unsigned rows, rr, i;
    logic [15:0] x, y, wmax, hgt;
    rows = live_rows();
    y = '0;
    wmax = '0;
    for (rr = 0; rr < rows; rr++) begin
      x = '0;
      hgt = (rr < n_glyphs) ? 16'(shelf[rr].h) : 16'd0;
      row_y[rr] = y;
      for (i = rr; i < n_glyphs; i += rows) x = x + shelf[i].w + pad_cfg;
      if (x > wmax) wmax = x;
      y = y + hgt + pad_cfg;
    end
    atlas_w_m = wmax;
    atlas_h_m = y;
    cur_row = 0;
    cur_slot = 0;
    cur_x = '0;
    laid_out = 1'b1;
  endfunction

  // Apply one accepted input word; queue the result word it causes, if any
  function automatic void pack_step(input glyph_word_t it);
    gpk_result_t r;
    int unsigned rows, idx, filled, p, k;
    bit found;
    r = '0;
    if (it.kind == KIND_CLEAR) begin
      n_glyphs = 0;
      rewind();
    end else if (it.kind == KIND_LOAD) begin
      if (n_glyphs >= GLYPH_CAP) begin
        r.status = STS_FULL;
        placements_due = {placements_due, r};
      end else begin
        // stable insert: after every glyph at least as tall
        p = 0;
        while (p < n_glyphs && shelf[p].h >= it.h) p++;
        for (k = n_glyphs; k > p; k--) shelf[k] = shelf[k-1];
        shelf[p] = '{code: it.code, w: it.w, h: it.h};
        n_glyphs++;
        rewind();
      end
    end else if (it.kind == KIND_READ) begin
      rows = live_rows();
      if (!laid_out) relayout();
      r.status = STS_EMPTY;
      r.atlas_w = atlas_w_m;
      r.atlas_h = atlas_h_m;
      found = 1'b0;
      while (!found && cur_row < rows) begin
        idx = cur_row + cur_slot * rows;
        if (idx < n_glyphs) begin
          filled = (n_glyphs < rows) ? n_glyphs : rows;
          r.status = STS_PLACED;
          r.code = shelf[idx].code;
          r.pos_x = cur_x;
          r.pos_y = row_y[cur_row];
          r.w = shelf[idx].w;
          r.h = shelf[idx].h;
          r.last = (idx + rows >= n_glyphs) && (cur_row + 1 >= filled);
          cur_x = cur_x + shelf[idx].w + pad_cfg;
          cur_slot++;
          found = 1'b1;
        end else begin
          cur_row++;
          cur_slot = 0;
          cur_x = '0;
        end
      end
      placements_due = {placements_due, r};
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_word(input gpk_result_t want);
    check_field("status", 16'(want.status), 16'(m_axis_tdata[1:0]));
    check_field("out_code", 16'(want.code), 16'(m_axis_tdata[9:2]));
    check_field("pos_x", want.pos_x, m_axis_tdata[25:10]);
    check_field("pos_y", want.pos_y, m_axis_tdata[41:26]);
    check_field("out_width", 16'(want.w), 16'(m_axis_tdata[49:42]));
    check_field("out_height", 16'(want.h), 16'(m_axis_tdata[57:50]));
    check_field("atlas_width", want.atlas_w, m_axis_tdata[73:58]);
    check_field("atlas_height", want.atlas_h, m_axis_tdata[89:74]);
    check_field("last", 16'(want.last), 16'(m_axis_tlast));
  endfunction

  // Input driver: predicts on acceptance, then presents the next word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pack_step(on_bus);
        taken_total++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (word_backlog.size() != 0 && (steady || $urandom_range(99) >= 11)) begin
          on_bus = word_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {on_bus.h, on_bus.w, on_bus.code};
          s_axis_tuser <= on_bus.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (placements_due.size() == 0) begin
          $display("%0t: unexpected word: expected none actual %0h last %0b",
                   $time, m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          check_word(placements_due.pop_front());
        end
      end
      m_axis_tready <= steady || ($urandom_range(99) >= 11);
    end
  end

  task automatic queue_word(input logic [1:0] kind, input logic [7:0] code,
                            input logic [7:0] w, input logic [7:0] h);
    glyph_word_t wd;
    wd = '{kind: kind, code: code, w: w, h: h};
    word_backlog = {word_backlog, wd};
    sent_total++;
    if (kind != KIND_SPARE) work_items++;
  endtask

  // Random glyph; heights often from a narrow range to force ties
  task automatic queue_glyph();
    logic [7:0] h;
    h = $urandom_range(1) ? 8'($urandom_range(4)) : 8'($urandom_range(255));
    queue_word(KIND_LOAD, 8'($urandom_range(255)), 8'($urandom_range(255)), h);
  endtask

  task automatic queue_noise();
    queue_word(2'($urandom_range(3)), 8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(255)));
  endtask

  // Wait until the block has taken every word and returned every result
  task automatic settle();
    while (taken_total != sent_total || placements_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic sel, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_ROW_COUNT) rows_cfg = value[ROWC_W-1:0];
    else pad_cfg = value[PAD_W-1:0];
    rewind();
  endtask

  initial begin : stimulus
    int unsigned phase, cfg_round, n, reads, k;
    logic [ROWC_W-1:0] row_picks[6];
    logic [PAD_W-1:0]  pad_picks[6];
    row_picks = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31, 5'd12};
    pad_picks = '{4'd0, 4'd15, 4'd3, 4'd0, 4'd15, 4'd1};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty read, ignored kind, field extremes, ties, rewind on load
    queue_word(KIND_READ, 8'd0, 8'd0, 8'd0);
    queue_word(KIND_SPARE, 8'hff, 8'hff, 8'hff);
    queue_word(KIND_LOAD, 8'd0, 8'd0, 8'd0);
    queue_word(KIND_LOAD, 8'd255, 8'd255, 8'd255);
    queue_word(KIND_LOAD, 8'd65, 8'd10, 8'd20);
    queue_word(KIND_LOAD, 8'd66, 8'd11, 8'd20);
    queue_word(KIND_LOAD, 8'd67, 8'd12, 8'd255);
    queue_word(KIND_LOAD, 8'd68, 8'd1, 8'd0);
    queue_word(KIND_READ, 8'd0, 8'd0, 8'd0);
    queue_word(KIND_READ, 8'd0, 8'd0, 8'd0);
    queue_word(KIND_LOAD, 8'd70, 8'd3, 8'd20);
    for (k = 0; k < 7; k++) queue_word(KIND_READ, 8'd0, 8'd0, 8'd0);
    queue_word(KIND_CLEAR, 8'd0, 8'd0, 8'd0);
    queue_word(KIND_READ, 8'd0, 8'd0, 8'd0);
    queue_word(KIND_SPARE, 8'd0, 8'd0, 8'd0);

    // Random phases: mostly clear, load a set, read it through and past the end
    phase = 0;
    cfg_round = 0;
    while (work_items < WORK_TARGET) begin
      if (phase % 3 == 0) begin
        settle();
        if (cfg_round < 6) begin
          reg_write(REG_ROW_COUNT, 32'(row_picks[cfg_round]));
          reg_write(REG_PADDING, 32'(pad_picks[cfg_round]));
        end else begin
          reg_write(REG_ROW_COUNT, 32'($urandom_range(31)));
          reg_write(REG_PADDING, 32'($urandom_range(15)));
        end
        cfg_round++;
      end
      steady = (phase >= 4 && phase < 9);
      if (phase == 2) begin
        // fill the store past capacity, then read every placement
        queue_word(KIND_CLEAR, 8'd0, 8'd0, 8'd0);
        for (k = 0; k < GLYPH_CAP + 2; k++) queue_glyph();
        for (k = 0; k < GLYPH_CAP + 2; k++) queue_word(KIND_READ, 8'd0, 8'd0, 8'd0);
      end else begin
        if ($urandom_range(99) < 80) queue_word(KIND_CLEAR, 8'd0, 8'd0, 8'd0);
        n = ($urandom_range(99) < 10) ? $urandom_range(20, 60) : $urandom_range(12);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(99) < 8) queue_noise();
          queue_glyph();
        end
        reads = n + $urandom_range(1, 3);
        for (k = 0; k < reads; k++) begin
          if ($urandom_range(99) < 5) queue_noise();
          queue_word(KIND_READ, 8'd0, 8'd0, 8'd0);
        end
      end
      phase++;
    end

    settle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== glyph_row_packer.f =====
src/gpk_pkg.sv
src/gpk_glyph_cell.sv
src/gpk_row_cell.sv
src/glyph_row_packer.sv
bench/tb.sv
